@@ rtl/srsw_pkg.sv @@
// Shared widths, codes and status encodings for the selective repeat sender window.
package srsw_pkg;

  localparam int SEQ_W     = 10;
  localparam int BASE_W    = 11;
  localparam int TOT_W     = 11;
  localparam int TMO_W     = 16;
  localparam int WIN_W     = 6;
  localparam int EV_W      = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // per-packet status
  localparam logic [1:0] ST_NOT_SENT = 2'd0;
  localparam logic [1:0] ST_SENT     = 2'd1;
  localparam logic [1:0] ST_ACKED    = 2'd2;

  // result event codes
  localparam logic [EV_W-1:0] EV_SEND    = 3'd0;
  localparam logic [EV_W-1:0] EV_RESEND  = 3'd1;
  localparam logic [EV_W-1:0] EV_ACK_OK  = 3'd2;
  localparam logic [EV_W-1:0] EV_ACK_DUP = 3'd3;
  localparam logic [EV_W-1:0] EV_ACK_BAD = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

  // input actions
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_ACK  = 1'b1;

endpackage

@@ rtl/srsw_cmd_if.sv @@
// Input channel: tick or acknowledgement words.
interface srsw_cmd_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [srsw_pkg::SEQ_W-1:0] ack_seq;
  logic                      ack_checksum_ok;
  logic [srsw_pkg::WIN_W-1:0] win_len;

  modport source (output valid, action, ack_seq, ack_checksum_ok, win_len, input ready);
  modport sink   (input valid, action, ack_seq, ack_checksum_ok, win_len, output ready);
endinterface

@@ rtl/srsw_evt_if.sv @@
// Output channel: event words.
interface srsw_evt_if;
  logic                       valid;
  logic                       ready;
  logic [srsw_pkg::EV_W-1:0]   event_res;
  logic [srsw_pkg::SEQ_W-1:0]  seq_no;
  logic [srsw_pkg::BASE_W-1:0] window_base;
  logic                       all_acked;
  logic                       last;

  modport source (output valid, event_res, seq_no, window_base, all_acked, last, input ready);
  modport sink   (input valid, event_res, seq_no, window_base, all_acked, last, output ready);
endinterface

@@ rtl/selective_repeat_sender_window.sv @@
// Top level of the selective repeat ARQ sender window.
//
//  port     dir  kind           payload
//  cmd      in   valid/ready    action, ack_seq, ack_checksum_ok, win_len
//  evt      out  valid/ready    event_res, seq_no, window_base, all_acked, last
//  cfg_*    in   write only     cfg_idx selects total_packets / timeout_ticks
//
// Pace: an ack reads and then writes its entry. A tick scans the W entries of the window,
//   steps the base over the A acked packets it finds, then emits the R results; the single
//   shared port of the packet memory (status + stamp) sets the pace.
// Reset: a clearing pass over all MAX_PACKETS entries marks every packet not sent; no word
//   is taken until it ends. Config writes are taken throughout.
// Stalls: the result register lets the next word in while the last result waits;
//   the sequencer holds while the result register is full.
module selective_repeat_sender_window #(
  parameter int MAX_PACKETS = 1024,
  parameter int MAX_WINDOW  = 32,
  parameter int STAMP_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [srsw_pkg::CFG_W-1:0]     cfg_data,
  srsw_cmd_if.sink                       cmd,
  srsw_evt_if.source                     evt
);

  localparam int AW    = $clog2(MAX_PACKETS);
  localparam int WC_W  = $clog2(MAX_WINDOW + 1);
  localparam int QA_W  = MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W = STAMP_WIDTH > srsw_pkg::TMO_W ? STAMP_WIDTH : srsw_pkg::TMO_W;
  localparam int ENT_W = 2 + STAMP_WIDTH;
  localparam int Q_W   = 1 + srsw_pkg::SEQ_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_PACKETS - 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SC_RD  = 4'd2;
  localparam logic [3:0] S_SC_WR  = 4'd3;
  localparam logic [3:0] S_AD_RD  = 4'd4;
  localparam logic [3:0] S_AD_CHK = 4'd5;
  localparam logic [3:0] S_EM_RD  = 4'd6;
  localparam logic [3:0] S_EM_LD  = 4'd7;
  localparam logic [3:0] S_ACK_RD = 4'd8;
  localparam logic [3:0] S_ACK_WR = 4'd9;

  logic [3:0]                    state;
  logic [srsw_pkg::TOT_W-1:0]    total_packets;
  logic [srsw_pkg::TMO_W-1:0]    timeout_ticks;
  logic [srsw_pkg::BASE_W-1:0]   base;
  logic [STAMP_WIDTH-1:0]        tick_clock;
  logic [AW-1:0]                 clr_addr;
  logic [WC_W-1:0]               scan_idx;
  logic [WC_W-1:0]               scan_len;
  logic [WC_W-1:0]               q_cnt;
  logic [WC_W-1:0]               em_idx;
  logic [srsw_pkg::SEQ_W-1:0]    ack_seq_r;
  logic                          ack_bad;

  // result register
  logic                          out_valid;
  logic [srsw_pkg::EV_W-1:0]     out_ev;
  logic [srsw_pkg::SEQ_W-1:0]    out_seq;
  logic [srsw_pkg::BASE_W-1:0]   out_base;
  logic                          out_all;
  logic                          out_last;
  logic                          out_free;
  logic                          out_load;

  // packet memory: {status, stamp}
  logic                          mem_we;
  logic [AW-1:0]                 mem_addr;
  logic [ENT_W-1:0]              mem_wdata;
  logic [ENT_W-1:0]              mem_rdata;
  logic [1:0]                    rd_status;
  logic [STAMP_WIDTH-1:0]        rd_stamp;

  // result queue: {resend flag, seq}
  logic                          q_we;
  logic [Q_W-1:0]                q_wdata;
  logic [Q_W-1:0]                q_rdata;

  logic [srsw_pkg::TOT_W-1:0]    total_eff;
  logic                          all_acked_c;
  logic [srsw_pkg::BASE_W-1:0]   scan_seq;
  logic [31:0]                   scan_wide;
  logic [31:0]                   base_wide;
  logic [31:0]                   ack_wide;
  logic [STAMP_WIDTH-1:0]        age;
  logic                          timed_out;
  logic [srsw_pkg::BASE_W-1:0]   rem_full;
  logic [WC_W-1:0]               win_eff;
  logic [WC_W-1:0]               scan_len_next;

  // packet count saturates at the memory depth
  assign total_eff   = (32'(total_packets) > MAX_PACKETS) ? srsw_pkg::TOT_W'(MAX_PACKETS)
                                                          : total_packets;
  assign all_acked_c = (base >= total_eff);

  assign scan_seq  = base + srsw_pkg::BASE_W'(scan_idx);
  assign scan_wide = 32'(scan_seq);
  assign base_wide = 32'(base);
  assign ack_wide  = 32'(ack_seq_r);

  assign rd_status = mem_rdata[ENT_W-1 -: 2];
  assign rd_stamp  = mem_rdata[STAMP_WIDTH-1:0];
  assign age       = tick_clock - rd_stamp;
  assign timed_out = CMP_W'(age) > CMP_W'(timeout_ticks);

  // scan length on a tick: min(packets left from base, window)
  assign rem_full      = (base < total_eff) ? (total_eff - base) : '0;
  assign win_eff       = (cmd.win_len > MAX_WINDOW) ? WC_W'(MAX_WINDOW)
                                                    : WC_W'(cmd.win_len);
  assign scan_len_next = (rem_full > srsw_pkg::BASE_W'(win_eff)) ? win_eff
                                                                 : WC_W'(rem_full);

  assign out_free  = !out_valid || evt.ready;
  // result register takes a new word in these two phases only
  assign out_load  = out_free && (state == S_EM_LD || state == S_ACK_WR);
  assign cmd.ready = (state == S_IDLE);

  assign evt.valid       = out_valid;
  assign evt.event_res   = out_ev;
  assign evt.seq_no      = out_seq;
  assign evt.window_base = out_base;
  assign evt.all_acked   = out_all;
  assign evt.last        = out_last;

  // memory address follows the phase of the sequencer
  always_comb begin
    unique case (state)
      S_CLEAR:           mem_addr = clr_addr;
      S_SC_RD, S_SC_WR:  mem_addr = scan_wide[AW-1:0];
      S_AD_RD, S_AD_CHK: mem_addr = base_wide[AW-1:0];
      default:           mem_addr = ack_wide[AW-1:0];
    endcase
  end

  // read-modify-write decisions
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = {srsw_pkg::ST_SENT, tick_clock};
    q_we      = 1'b0;
    q_wdata   = {1'b0, scan_seq[srsw_pkg::SEQ_W-1:0]};
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {srsw_pkg::ST_NOT_SENT, {STAMP_WIDTH{1'b0}}};
      end
      S_SC_WR: begin
        if (rd_status == srsw_pkg::ST_NOT_SENT) begin
          mem_we = 1'b1;
          q_we   = 1'b1;
        end else if (rd_status == srsw_pkg::ST_SENT && timed_out) begin
          mem_we  = 1'b1;
          q_we    = 1'b1;
          q_wdata = {1'b1, scan_seq[srsw_pkg::SEQ_W-1:0]};
        end
      end
      S_ACK_WR: begin
        if (out_free && !ack_bad && rd_status != srsw_pkg::ST_ACKED) begin
          mem_we    = 1'b1;
          mem_wdata = {srsw_pkg::ST_ACKED, rd_stamp};
        end
      end
      default: ;
    endcase
  end

  srsw_ram #(.WIDTH(ENT_W), .DEPTH(MAX_PACKETS)) u_pkt_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  // results of one tick wait here until the base has settled
  srsw_ram #(.WIDTH(Q_W), .DEPTH(MAX_WINDOW)) u_res_q (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_cnt[QA_W-1:0]),
    .wdata (q_wdata),
    .raddr (em_idx[QA_W-1:0]),
    .rdata (q_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets <= '0;
      timeout_ticks <= srsw_pkg::TMO_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        srsw_pkg::REG_TOTAL:   total_packets <= cfg_data[srsw_pkg::TOT_W-1:0];
        srsw_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data[srsw_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      base       <= '0;
      tick_clock <= '0;
      scan_idx   <= '0;
      scan_len   <= '0;
      q_cnt      <= '0;
      em_idx     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.action == srsw_pkg::ACT_TICK) begin
              tick_clock <= tick_clock + STAMP_WIDTH'(1);
              scan_idx   <= '0;
              scan_len   <= scan_len_next;
              q_cnt      <= '0;
              em_idx     <= '0;
              state      <= S_SC_RD;
            end else begin
              ack_seq_r <= cmd.ack_seq;
              ack_bad   <= !cmd.ack_checksum_ok || ({1'b0, cmd.ack_seq} >= total_eff);
              state     <= S_ACK_RD;
            end
          end
        end
        S_SC_RD: begin
          state <= (scan_idx == scan_len) ? S_AD_RD : S_SC_WR;
        end
        S_SC_WR: begin
          if (q_we) begin
            q_cnt <= q_cnt + WC_W'(1);
          end
          scan_idx <= scan_idx + WC_W'(1);
          state    <= S_SC_RD;
        end
        S_AD_RD: begin
          state <= all_acked_c ? S_EM_RD : S_AD_CHK;
        end
        S_AD_CHK: begin
          if (rd_status == srsw_pkg::ST_ACKED) begin
            base  <= base + srsw_pkg::BASE_W'(1);
            state <= S_AD_RD;
          end else begin
            state <= S_EM_RD;
          end
        end
        S_EM_RD: begin
          state <= (em_idx == q_cnt) ? S_IDLE : S_EM_LD;
        end
        S_EM_LD: begin
          if (out_free) begin
            out_ev    <= q_rdata[srsw_pkg::SEQ_W] ? srsw_pkg::EV_RESEND : srsw_pkg::EV_SEND;
            out_seq   <= q_rdata[srsw_pkg::SEQ_W-1:0];
            out_base  <= base;
            out_all   <= all_acked_c;
            out_last  <= ((em_idx + WC_W'(1)) == q_cnt);
            em_idx    <= em_idx + WC_W'(1);
            state     <= S_EM_RD;
          end
        end
        S_ACK_RD: begin
          state <= S_ACK_WR;
        end
        S_ACK_WR: begin
          if (out_free) begin
            priority if (ack_bad) begin
              out_ev <= srsw_pkg::EV_ACK_BAD;
            end else if (rd_status == srsw_pkg::ST_ACKED) begin
              out_ev <= srsw_pkg::EV_ACK_DUP;
            end else begin
              out_ev <= srsw_pkg::EV_ACK_OK;
            end
            out_seq  <= ack_seq_r;
            out_base <= base;
            out_all  <= all_acked_c;
            out_last <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an ack gives exactly one result word
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_ev == srsw_pkg::EV_ACK_OK || out_ev == srsw_pkg::EV_ACK_DUP ||
                   out_ev == srsw_pkg::EV_ACK_BAD)) |-> out_last)
    else $error("ack result without last");

  // queued results never outnumber scanned entries
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (q_cnt <= scan_len) && (em_idx <= q_cnt))
    else $error("result queue count out of bounds");

  // the window base only moves forward
  a_base_fwd: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (base >= $past(base)))
    else $error("window base moved back");

  // nothing leaves before the clearing pass is over
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result during clearing pass");

endmodule

@@ rtl/srsw_ram.sv @@
// Generic simple dual-port RAM, registered read.
module srsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/srsw_event_check.sv @@
// Result checker for the selective repeat sender window: predicts event words and compares them.
module srsw_event_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [srsw_pkg::CFG_W-1:0]     cfg_data,
  srsw_cmd_if                            cmd,
  srsw_evt_if                            evt,
  output int                             misses,
  output int                             pending
);

  localparam int MAX_PKT   = 1024;
  localparam int MAX_WIN   = 32;
  localparam int STAMP_W   = 32;

  typedef struct packed {
    logic [srsw_pkg::EV_W-1:0]   code;
    logic [srsw_pkg::SEQ_W-1:0]  seq;
    logic [srsw_pkg::BASE_W-1:0] base;
    logic                        done;
    logic                        last;
  } evt_word_t;

  logic [1:0]                 pkt_state [MAX_PKT];
  logic [STAMP_W-1:0]         pkt_stamp [MAX_PKT];
  int unsigned                head;
  logic [STAMP_W-1:0]         ticks;
  logic [srsw_pkg::TOT_W-1:0] tot_reg;
  logic [srsw_pkg::TMO_W-1:0] tmo_reg;
  evt_word_t                  due_events[$];
  int                         miss_count = 0;

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    miss_count++;
  endtask

  // one accepted command word -> the event words it causes
  task automatic predict_events(input logic act, input logic [srsw_pkg::SEQ_W-1:0] aseq,
                                input logic ok, input logic [srsw_pkg::WIN_W-1:0] wsz);
    evt_word_t          fresh[$];
    evt_word_t          w;
    int unsigned        cap;
    int unsigned        span;
    int unsigned        avail;
    int unsigned        idx;
    logic [STAMP_W-1:0] age;
    cap = (tot_reg > MAX_PKT) ? MAX_PKT : tot_reg;
    if (act == srsw_pkg::ACT_TICK) begin
      span  = (wsz > MAX_WIN) ? MAX_WIN : wsz;
      ticks = ticks + 1'b1;
      avail = (head < cap) ? cap - head : 0;
      if (avail > span) avail = span;
      for (idx = head; idx < head + avail; idx++) begin
        if (pkt_state[idx] == srsw_pkg::ST_NOT_SENT) begin
          pkt_state[idx] = srsw_pkg::ST_SENT;
          pkt_stamp[idx] = ticks;
          w      = '0;
          w.code = srsw_pkg::EV_SEND;
          w.seq  = srsw_pkg::SEQ_W'(idx);
          fresh.push_back(w);
        end else if (pkt_state[idx] == srsw_pkg::ST_SENT) begin
          age = ticks - pkt_stamp[idx];
          if (age > STAMP_W'(tmo_reg)) begin
            pkt_stamp[idx] = ticks;
            w      = '0;
            w.code = srsw_pkg::EV_RESEND;
            w.seq  = srsw_pkg::SEQ_W'(idx);
            fresh.push_back(w);
          end
        end
      end
      while (head < cap && pkt_state[head] == srsw_pkg::ST_ACKED) head++;
    end else begin
      w     = '0;
      w.seq = aseq;
      if (!ok || aseq >= cap) begin
        w.code = srsw_pkg::EV_ACK_BAD;
      end else if (pkt_state[aseq] == srsw_pkg::ST_ACKED) begin
        w.code = srsw_pkg::EV_ACK_DUP;
      end else begin
        pkt_state[aseq] = srsw_pkg::ST_ACKED;
        w.code          = srsw_pkg::EV_ACK_OK;
      end
      fresh.push_back(w);
    end
    foreach (fresh[k]) begin
      fresh[k].base = srsw_pkg::BASE_W'(head);
      fresh[k].done = (head >= cap);
      fresh[k].last = (k == fresh.size() - 1);
      due_events.push_back(fresh[k]);
    end
  endtask

  always @(posedge clk) begin
    evt_word_t want;
    evt_word_t got;
    if (rst) begin
      for (int i = 0; i < MAX_PKT; i++) begin
        pkt_state[i] = srsw_pkg::ST_NOT_SENT;
        pkt_stamp[i] = '0;
      end
      head    = 0;
      ticks   = '0;
      tot_reg = '0;
      tmo_reg = srsw_pkg::TMO_W'(100);
      due_events.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          srsw_pkg::REG_TOTAL:   tot_reg = cfg_data[srsw_pkg::TOT_W-1:0];
          srsw_pkg::REG_TIMEOUT: tmo_reg = cfg_data[srsw_pkg::TMO_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        predict_events(cmd.action, cmd.ack_seq, cmd.ack_checksum_ok, cmd.win_len);
      if (evt.valid && evt.ready) begin
        got = '{evt.event_res, evt.seq_no, evt.window_base, evt.all_acked, evt.last};
        if (due_events.size() == 0) begin
          flag_mismatch("unexpected word, seq_no", 0, got.seq);
        end else begin
          want = due_events.pop_front();
          if (got.code != want.code) flag_mismatch("event_res", want.code, got.code);
          if (got.seq != want.seq)   flag_mismatch("seq_no", want.seq, got.seq);
          if (got.base != want.base) flag_mismatch("window_base", want.base, got.base);
          if (got.done != want.done) flag_mismatch("all_acked", want.done, got.done);
          if (got.last != want.last) flag_mismatch("last", want.last, got.last);
        end
      end
    end
    pending <= due_events.size();
    misses  <= miss_count;
  end

endmodule

@@ tb/testbench.sv @@
// Top of the sender window testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;

  localparam int PKT_CAP   = 1024;
  localparam int WIN_CAP   = 32;
  // worst tick: full window, base stepping over every packet, a result per entry
  localparam int SETTLE    = 2400;
  localparam int LONG_HOLD = 400;
  // covers the clearing pass, a settle pause and the long hold with room to spare
  localparam int WATCHDOG  = 20000;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [srsw_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [srsw_pkg::CFG_W-1:0]     cfg_data;

  srsw_cmd_if cmd_bus ();
  srsw_evt_if evt_bus ();

  int misses;
  int pending;

  // stimulus bookkeeping only: which packets were acked and roughly where the base sits,
  // so that most acks land inside the live window
  bit          acked_mark [PKT_CAP];
  int unsigned base_guess = 0;
  int unsigned cap_now    = 0;
  bit          src_steady = 1'b0;
  logic        hold_armed;
  int unsigned idle_cycles = 0;

  selective_repeat_sender_window DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cmd      (cmd_bus),
    .evt      (evt_bus)
  );

  srsw_event_check window_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cmd      (cmd_bus),
    .evt      (evt_bus),
    .misses   (misses),
    .pending  (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly back to back, some short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random back-pressure, calm stretches, one long hold once armed
  initial begin : result_sink
    int stall;
    bit steady;
    bit held;
    stall  = 0;
    steady = 1'b0;
    held   = 1'b0;
    evt_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 149) == 0) steady = !steady;
      if (hold_armed && !held) begin
        held  = 1'b1;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        evt_bus.ready <= 1'b0;
        stall--;
      end else begin
        evt_bus.ready <= 1'b1;
        if (!steady) stall = idle_len();
      end
    end
  end

  // no word moving on either side for too long: give up
  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (evt_bus.valid && evt_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("selective_repeat_sender_window verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one word; valid stays up into the next call unless a gap is drawn
  task automatic send_word(input logic act, input logic [srsw_pkg::SEQ_W-1:0] aseq,
                           input logic ok, input logic [srsw_pkg::WIN_W-1:0] wsz);
    int gap;
    cmd_bus.valid           <= 1'b1;
    cmd_bus.action          <= act;
    cmd_bus.ack_seq         <= aseq;
    cmd_bus.ack_checksum_ok <= ok;
    cmd_bus.win_len         <= wsz;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : idle_len();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick(input logic [srsw_pkg::WIN_W-1:0] wsz);
    send_word(srsw_pkg::ACT_TICK, srsw_pkg::SEQ_W'($urandom), 1'($urandom), wsz);
  endtask

  task automatic send_ack(input logic [srsw_pkg::SEQ_W-1:0] aseq, input logic ok);
    if (ok && aseq < cap_now) acked_mark[aseq] = 1'b1;
    send_word(srsw_pkg::ACT_ACK, aseq, ok, srsw_pkg::WIN_W'($urandom));
  endtask

  // mostly window traffic: ticks and good acks just above the base; some noise
  task automatic random_word();
    int          r;
    int unsigned s;
    while (base_guess < cap_now && acked_mark[base_guess]) base_guess++;
    r = $urandom_range(0, 99);
    if (r < 48) begin
      if ($urandom_range(0, 9) == 0) send_tick(srsw_pkg::WIN_W'($urandom_range(0, 63)));
      else send_tick(srsw_pkg::WIN_W'($urandom_range(1, WIN_CAP)));
    end else if (r < 90) begin
      s = base_guess + $urandom_range(0, WIN_CAP - 1);
      if (s >= PKT_CAP) s = $urandom_range(0, PKT_CAP - 1);
      send_ack(srsw_pkg::SEQ_W'(s), $urandom_range(0, 19) != 0);
    end else begin
      send_ack(srsw_pkg::SEQ_W'($urandom_range(0, PKT_CAP - 1)), 1'($urandom));
    end
  endtask

  task automatic write_reg(input logic [srsw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srsw_pkg::CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait for every predicted word to come out
  task automatic drain();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // a tick may still be stepping the base with no word to show for it
  task automatic settle();
    drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= srsw_pkg::REG_TOTAL;
    cfg_data                <= '0;
    cmd_bus.valid           <= 1'b0;
    cmd_bus.action          <= srsw_pkg::ACT_TICK;
    cmd_bus.ack_seq         <= '0;
    cmd_bus.ack_checksum_ok <= 1'b0;
    cmd_bus.win_len         <= '0;
    hold_armed              <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset values, no packets at all: tick scans nothing, any ack is rejected
    send_tick(srsw_pkg::WIN_W'(5));
    send_ack(srsw_pkg::SEQ_W'(0), 1'b1);
    settle();

    // small transfer, short timeout: directed corners first
    write_reg(srsw_pkg::REG_TOTAL, srsw_pkg::CFG_W'(40));
    write_reg(srsw_pkg::REG_TIMEOUT, srsw_pkg::CFG_W'(3));
    cap_now = 40;
    send_tick(srsw_pkg::WIN_W'(0));            // zero window: nothing scanned
    send_tick(srsw_pkg::WIN_W'(63));           // saturates to full window, first sends
    send_tick(srsw_pkg::WIN_W'(1));            // too young to resend
    send_ack(srsw_pkg::SEQ_W'(5), 1'b0);       // bad checksum
    send_ack(srsw_pkg::SEQ_W'(1023), 1'b1);    // far out of range
    send_ack(srsw_pkg::SEQ_W'(40), 1'b1);      // one past the last packet
    send_ack(srsw_pkg::SEQ_W'(0), 1'b1);
    send_ack(srsw_pkg::SEQ_W'(0), 1'b1);       // duplicate
    send_ack(srsw_pkg::SEQ_W'(39), 1'b1);      // never sent, still accepted
    send_ack(srsw_pkg::SEQ_W'(1), 1'b1);
    send_ack(srsw_pkg::SEQ_W'(2), 1'b1);
    send_tick(srsw_pkg::WIN_W'(33));           // base steps over the acked head
    send_tick(srsw_pkg::WIN_W'(32));
    send_tick(srsw_pkg::WIN_W'(32));           // ages now past the timeout: resends
    repeat (80) random_word();
    settle();

    // oversized packet count, longest timeout
    write_reg(srsw_pkg::REG_TOTAL, srsw_pkg::CFG_W'(16'hFFFF));
    write_reg(srsw_pkg::REG_TIMEOUT, srsw_pkg::CFG_W'(16'hFFFF));
    cap_now = PKT_CAP;
    repeat (40) random_word();
    drain();                         // sender waits for every result mid-phase
    repeat (40) random_word();
    settle();

    // count lowered under the base, zero timeout
    write_reg(srsw_pkg::REG_TOTAL, srsw_pkg::CFG_W'(5));
    write_reg(srsw_pkg::REG_TIMEOUT, srsw_pkg::CFG_W'(0));
    cap_now = 5;
    send_tick(srsw_pkg::WIN_W'(32));
    send_ack(srsw_pkg::SEQ_W'(3), 1'b1);
    send_ack(srsw_pkg::SEQ_W'(7), 1'b1);
    repeat (20) random_word();
    settle();

    // full transfer, timeout of one: heavy resend traffic, plus the long receiver hold
    write_reg(srsw_pkg::REG_TOTAL, srsw_pkg::CFG_W'(PKT_CAP));
    write_reg(srsw_pkg::REG_TIMEOUT, srsw_pkg::CFG_W'(1));
    cap_now = PKT_CAP;
    hold_armed <= 1'b1;
    repeat (90) random_word();
    settle();

    // empty transfer written explicitly
    write_reg(srsw_pkg::REG_TOTAL, srsw_pkg::CFG_W'(0));
    cap_now = 0;
    repeat (5) random_word();
    settle();

    if (misses == 0 && pending == 0)
      $display("selective_repeat_sender_window verification clean");
    else
      $display("selective_repeat_sender_window verification failed");
    $finish;
  end

endmodule
